// ===== rtl/stepper_move_controller_macros.svh =====
// assertion macros for the stepper move controller
// used by stepper_move_controller.sv, no other dependencies
`ifndef STEPPER_MOVE_CONTROLLER_MACROS_SVH
`define STEPPER_MOVE_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/smc_pkg.sv =====
// shared types and constants of the stepper move controller
// no dependencies
package smc_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_MOVE_BY = 3'd1,
    OP_MOVE_TO = 3'd2,
    OP_ZERO    = 3'd3,
    OP_CLEAR   = 3'd4
  } smc_op_t;

  localparam int DEG_W   = 10;
  localparam int POS_W   = 16;
  localparam int COIL_W  = 4;

  localparam logic [COIL_W-1:0] COIL_CW_FIRST  = 4'b1000;
  localparam logic [COIL_W-1:0] COIL_CCW_FIRST = 4'b0001;

  // reciprocals for division by constants
  localparam logic [16:0] RECIP_100 = 17'd83887;  // x/100 = (x*RECIP_100) >> 23
  localparam logic [15:0] RECIP_17  = 16'd61681;  // x/17  = (x*RECIP_17)  >> 20

  // position change requested by the execute stage
  typedef struct packed {
    logic inc;
    logic dec;
    logic clr;
  } smc_pos_cmd_t;

endpackage

// ===== rtl/smc_move_scale.sv =====
// converts an angle in degrees to a step count: ((deg*100)/17)*3, 16-bit wrap
// depends on smc_pkg
module smc_move_scale
  import smc_pkg::*;
(
  input  logic [DEG_W-1:0] degrees,
  output logic [15:0]      steps
);

  logic [15:0] scaled;
  logic [31:0] prod;
  logic [11:0] quot;
  logic [13:0] triple;

  always_comb begin
    scaled = 16'((32'(degrees) << 6) + (32'(degrees) << 5) + (32'(degrees) << 2));
    prod   = 32'(scaled) * 32'(RECIP_17);
    quot   = prod[31:20];
    triple = 14'({2'b00, quot} + {1'b0, quot, 1'b0});
    steps  = {2'b00, triple};
  end

endmodule

// ===== rtl/smc_angle_track.sv =====
// tracks position/3 incrementally and registers the present angle
// ((position/3)*17)/100 with 16-bit wrap; depends on smc_pkg
module smc_angle_track
  import smc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  smc_pos_cmd_t     pos_cmd,
  input  logic [POS_W-1:0] position,
  output logic [DEG_W-1:0] angle
);

  logic [14:0] thirds;
  logic [14:0] thirds_next;
  logic [1:0]  rem;
  logic [1:0]  rem_next;
  logic [15:0] prod17;
  logic [32:0] prod_div;

  always_comb begin
    thirds_next = thirds;
    rem_next    = rem;
    if (pos_cmd.clr) begin
      thirds_next = '0;
      rem_next    = '0;
    end else if (pos_cmd.inc) begin
      if (position == '1) begin
        thirds_next = '0;
        rem_next    = '0;
      end else if (rem == 2'd2) begin
        thirds_next = thirds + 15'd1;
        rem_next    = 2'd0;
      end else begin
        rem_next = rem + 2'd1;
      end
    end else if (pos_cmd.dec) begin
      if (rem == 2'd0) begin
        thirds_next = thirds - 15'd1;
        rem_next    = 2'd2;
      end else begin
        rem_next = rem - 2'd1;
      end
    end
    prod17   = 16'((32'(thirds_next) << 4) + 32'(thirds_next));
    prod_div = 33'(prod17) * 33'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thirds <= '0;
      rem    <= '0;
      angle  <= '0;
    end else begin
      thirds <= thirds_next;
      rem    <= rem_next;
      angle  <= prod_div[32:23];
    end
  end

endmodule

// ===== rtl/stepper_move_controller.sv =====
// Wave-drive stepper move controller. Requests carry an operation in s_tuser (tick, move by,
// move to, zero position, clear done) and one result per request leaves on m_tdata. A request
// is registered, executed against the motor state once the result register can advance and
// written to the result register, so one request per cycle is taken while results are taken as
// fast; the whole path runs at one request per clock while m_tready does not hold it back.
// The present angle for move-to is kept in a register that follows the position.
// depends on smc_pkg, smc_move_scale, smc_angle_track, stepper_move_controller_macros.svh
`include "stepper_move_controller_macros.svh"

module stepper_move_controller
  import smc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // degrees[9:0], clockwise[10], zero pad
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // coil_drive[3:0], step_taken[4], position[20:5], done_res[21]
);

  logic             in_valid;
  logic [2:0]       in_op;
  logic [DEG_W-1:0] in_deg;
  logic             in_cw;

  logic [POS_W-1:0] step_position;
  logic [POS_W-1:0] step_position_next;
  logic [15:0]      steps_remaining;
  logic [15:0]      steps_remaining_next;
  logic [1:0]       coil_index;
  logic [1:0]       coil_index_next;
  logic             dir_cw;
  logic             dir_cw_next;
  logic             done_flag;
  logic             done_flag_next;
  logic             running;
  logic             running_next;

  logic [COIL_W-1:0] coil_res;
  logic              step_res;
  logic [COIL_W-1:0] out_coil;
  logic              out_step;
  logic [POS_W-1:0]  out_pos;
  logic              out_done;

  logic             advance;
  logic             exec;
  smc_pos_cmd_t     pos_cmd;
  logic [DEG_W-1:0] angle;
  logic             to_cw;
  logic [DEG_W-1:0] to_diff;
  logic [DEG_W-1:0] scale_deg;
  logic [15:0]      scale_steps;

  assign advance  = !m_tvalid || m_tready;
  assign exec     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign to_cw     = in_deg > angle;
  assign to_diff   = to_cw ? (in_deg - angle) : (angle - in_deg);
  assign scale_deg = (in_op == OP_MOVE_TO) ? to_diff : in_deg;

  smc_move_scale u_scale (
    .degrees (scale_deg),
    .steps   (scale_steps)
  );

  smc_angle_track u_angle (
    .clk      (clk),
    .rst      (rst),
    .pos_cmd  (pos_cmd),
    .position (step_position),
    .angle    (angle)
  );

  always_comb begin
    step_position_next   = step_position;
    steps_remaining_next = steps_remaining;
    coil_index_next      = coil_index;
    dir_cw_next          = dir_cw;
    done_flag_next       = done_flag;
    running_next         = running;
    pos_cmd              = '0;
    coil_res             = '0;
    step_res             = 1'b0;
    if (exec) begin
      unique case (in_op)
        OP_TICK: begin
          if (running) begin
            step_res = 1'b1;
            if (dir_cw) begin
              coil_res           = COIL_CW_FIRST >> coil_index;
              step_position_next = step_position + 16'd1;
              pos_cmd.inc        = 1'b1;
            end else begin
              coil_res = COIL_CCW_FIRST << coil_index;
              if (step_position != '0) begin
                step_position_next = step_position - 16'd1;
                pos_cmd.dec        = 1'b1;
              end
            end
            coil_index_next = coil_index + 2'd1;
            if (steps_remaining != '0) begin
              steps_remaining_next = steps_remaining - 16'd1;
            end else begin
              done_flag_next = 1'b1;
              running_next   = 1'b0;
            end
          end
        end
        OP_MOVE_BY: begin
          dir_cw_next          = in_cw;
          steps_remaining_next = scale_steps;
          running_next         = 1'b1;
        end
        OP_MOVE_TO: begin
          done_flag_next       = 1'b0;
          dir_cw_next          = to_cw;
          steps_remaining_next = scale_steps;
          running_next         = 1'b1;
        end
        OP_ZERO: begin
          step_position_next = '0;
          pos_cmd.clr        = 1'b1;
        end
        OP_CLEAR: begin
          done_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      step_position   <= '0;
      steps_remaining <= '0;
      coil_index      <= '0;
      dir_cw          <= 1'b0;
      done_flag       <= 1'b0;
      running         <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (exec) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
      step_position   <= step_position_next;
      steps_remaining <= steps_remaining_next;
      coil_index      <= coil_index_next;
      dir_cw          <= dir_cw_next;
      done_flag       <= done_flag_next;
      running         <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_deg <= s_tdata[DEG_W-1:0];
      in_cw  <= s_tdata[DEG_W];
    end
    if (exec) begin
      out_coil <= coil_res;
      out_step <= step_res;
      out_pos  <= step_position_next;
      out_done <= done_flag_next;
    end
  end

  assign m_tdata = {2'b00, out_done, out_pos, out_step, out_coil};

  `SMC_ASSERT_NOW(a_coil_onehot, clk, rst, m_tvalid && out_step, $onehot(out_coil))
  `SMC_ASSERT_NOW(a_coil_idle, clk, rst, m_tvalid && !out_step, out_coil == '0)
  `SMC_ASSERT_NEXT(a_final_tick, clk, rst,
    exec && in_op == OP_TICK && running && steps_remaining == '0, !running && done_flag)
  `SMC_ASSERT_NEXT(a_ccw_floor, clk, rst,
    exec && in_op == OP_TICK && running && !dir_cw && step_position == '0,
    step_position == '0)

endmodule
